[sv/cnr_pkg.sv]
// Shared types, constants and saturating helpers for the cubic Newton root block.
package cnr_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 24;
	localparam int CNT_W  = 16;
	localparam int EPS_W  = 31;
	localparam int OP_W   = WORD_W + 2;
	localparam int ACC_W  = 2 * WORD_W + 1;
	localparam int DIV_STEPS = 2 * WORD_W + FRAC_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [OP_W-1:0] op_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam word_t W_MAX = 32'sh7FFFFFFF;
	localparam word_t W_MIN = 32'sh80000000;
	localparam word_t W_ONE = 32'sh01000000;
	localparam word_t W_TWO = 32'sh02000000;
	localparam op_t   RECIP3 = 34'sh0AAAAAAAB;

	localparam logic [1:0] ROOT_ZERO = 2'd0;
	localparam logic [1:0] ROOT_ONE  = 2'd1;
	localparam logic [1:0] ROOT_D    = 2'd2;
	localparam logic [1:0] ROOT_NONE = 2'd3;

	localparam logic REG_EPS   = 1'b0;
	localparam logic REG_MAXIT = 1'b1;

	typedef struct packed {
		word_t re;
		word_t im;
	} cplx_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] c_re;
		logic signed [WORD_W-1:0] c_im;
	} in_req_t;

	typedef struct packed {
		logic [1:0]       root_found;
		logic [CNT_W-1:0] iterations;
	} out_req_t;

	typedef struct packed {
		logic mul;
		logic acc;
		logic sub;
		logic clr;
	} mac_ctl_t;

	typedef enum logic [1:0] {MODE_ZERO, MODE_ONE, MODE_GEN} mode_t;
	typedef enum logic [1:0] {JOB_INIT, JOB_NEAR, JOB_CMUL, JOB_DIV} job_t;
	typedef enum logic [3:0] {
		PC_CHK, PC_N0, PC_N1, PC_N2, PC_T0, PC_T1, PC_M0, PC_M1, PC_DIV
	} pc_t;
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_RES, ST_PC, ST_DIVGO, ST_DIVW, ST_DONE
	} st_t;
	typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_st_t;

	function automatic word_t sat35(input logic signed [WORD_W+2:0] v);
		if (v > 35'(W_MAX)) return W_MAX;
		if (v < 35'(W_MIN)) return W_MIN;
		return v[WORD_W-1:0];
	endfunction

	function automatic word_t sat_acc(input acc_t v);
		acc_t s;
		s = v >>> FRAC_W;
		if (s > 65'(W_MAX)) return W_MAX;
		if (s < 65'(W_MIN)) return W_MIN;
		return s[WORD_W-1:0];
	endfunction

	function automatic cplx_t creal(input word_t v);
		cplx_t r;
		r.re = v;
		r.im = '0;
		return r;
	endfunction

	function automatic cplx_t cadd(input cplx_t a, input cplx_t b);
		cplx_t r;
		r.re = sat35(35'(a.re) + 35'(b.re));
		r.im = sat35(35'(a.im) + 35'(b.im));
		return r;
	endfunction

	function automatic cplx_t csub(input cplx_t a, input cplx_t b);
		cplx_t r;
		r.re = sat35(35'(a.re) - 35'(b.re));
		r.im = sat35(35'(a.im) - 35'(b.im));
		return r;
	endfunction

	function automatic cplx_t cx2(input cplx_t a);
		cplx_t r;
		r.re = sat35(35'(a.re) + 35'(a.re));
		r.im = sat35(35'(a.im) + 35'(a.im));
		return r;
	endfunction

	function automatic cplx_t cx3(input cplx_t a);
		cplx_t r;
		r.re = sat35(35'(a.re) + 35'(a.re) + 35'(a.re));
		r.im = sat35(35'(a.im) + 35'(a.im) + 35'(a.im));
		return r;
	endfunction

endpackage

[sv/cnr_mac.sv]
// Shared registered multiplier with signed accumulator.
module cnr_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  cnr_pkg::mac_ctl_t ctl,
	input  cnr_pkg::op_t      op_a,
	input  cnr_pkg::op_t      op_b,
	output cnr_pkg::acc_t     acc
);
	import cnr_pkg::*;

	logic signed [2*OP_W-1:0] prod_q;
	acc_t acc_q;
	acc_t p;
	acc_t base;

	assign p    = prod_q[ACC_W-1:0];
	assign base = ctl.clr ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= op_a * op_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= ctl.sub ? base - p : base + p;
		end
	end

	assign acc = acc_q;

endmodule

[sv/cnr_div.sv]
// Restoring serial divider: saturated fixed-point quotient, one bit per cycle.
module cnr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cnr_pkg::acc_t        num,
	input  logic [2*cnr_pkg::WORD_W-1:0] den,
	output logic                 done,
	output cnr_pkg::word_t       quo
);
	import cnr_pkg::*;

	dv_st_t st_q, st_d;
	logic neg_q;
	logic [2*WORD_W-1:0] mag_q, shf_q, den_q, rem_q;
	logic [WORD_W:0] quo_q;
	logic ovf_q;
	logic [DCNT_W-1:0] cnt_q;
	word_t res_q;
	logic done_q;
	logic [2*WORD_W:0] rem_sh, rem_sub;
	logic ge;
	logic [WORD_W:0] lim;
	word_t sat_v, fin_v;
	acc_t num_abs;

	assign rem_sh  = {rem_q, shf_q[2*WORD_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign num_abs = num[ACC_W-1] ? -num : num;
	assign lim     = neg_q ? {2'b01, {(WORD_W-1){1'b0}}} : {2'b00, {(WORD_W-1){1'b1}}};
	assign sat_v   = neg_q ? W_MIN : W_MAX;

	always_comb begin
		if (den_q == '0) begin
			fin_v = (mag_q == '0) ? '0 : sat_v;
		end else if (ovf_q || quo_q > lim) begin
			fin_v = sat_v;
		end else begin
			fin_v = neg_q ? -quo_q[WORD_W-1:0] : quo_q[WORD_W-1:0];
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			DV_IDLE: if (start) st_d = DV_RUN;
			DV_RUN:  if (cnt_q == DCNT_W'(DIV_STEPS - 1)) st_d = DV_FIN;
			DV_FIN:  st_d = DV_IDLE;
			default: st_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DV_FIN);
			if (st_q == DV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (start) begin
					neg_q <= num[ACC_W-1];
					mag_q <= num_abs[2*WORD_W-1:0];
					shf_q <= num_abs[2*WORD_W-1:0];
					den_q <= den;
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			DV_RUN: begin
				shf_q <= {shf_q[2*WORD_W-2:0], 1'b0};
				rem_q <= ge ? rem_sub[2*WORD_W-1:0] : rem_sh[2*WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-1:0], ge};
				ovf_q <= ovf_q | quo_q[WORD_W];
			end
			DV_FIN: res_q <= fin_v;
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = res_q;

endmodule

[sv/cubic_newton_root_convergence.sv]
// Top level: Newton root convergence sequencer for the cubic with roots 0, 1 and d.
//
// Usage: a request on in_req (c_re, c_im, signed Q8.24) is taken when in_valid is
// high and in_stall low. in_stall stays high from then until the result has been
// taken. The result (root_found, iterations) is shown on out_req with out_valid
// high until a cycle with out_stall low; it holds unchanged while out_stall is high.
// Configuration (epsilon, max_iterations) is written through cfg_wr_en, cfg_index and
// cfg_data; the user must do so only while the block is idle, which the block itself
// does not enforce. Reset loads 168 and 500. One shared multiply-accumulate unit and
// one restoring divider do all work; real products are taken in pairs. Start-up covers
// the start point and limit check; each Newton step runs the distance tests, the
// complex products and a division of 88 quotient bits plus start and finish. When d is
// exactly 0 or 1 a Newton step skips the distance test against d and two of its complex
// products. One request at a time; the next can be taken in the cycle after the result is taken.
// Reset clears the sequencer and returns the block to idle with no result pending.
module cubic_newton_root_convergence (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [cnr_pkg::EPS_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cnr_pkg::in_req_t     in_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cnr_pkg::out_req_t    out_req
);
	import cnr_pkg::*;

	st_t st_q, st_d;
	pc_t pc_q;
	job_t job_q;
	mode_t mode_q;
	logic [2:0] k_q;
	logic [EPS_W-1:0] eps_q;
	logic [CNT_W-1:0] maxit_q, i_q;
	logic [1:0] root_q;
	logic dsel_q;
	cplx_t d_q, x_q, t_q, m_q, opa_q, opb_q;
	word_t cre_q;
	logic [2*WORD_W-1:0] den_q;
	acc_t nre_q, nim_q;

	mac_ctl_t mac_ctl;
	op_t op_a, op_b;
	acc_t acc;
	logic div_start, div_done;
	word_t div_quo;

	logic [2:0] last_k;
	logic near;
	logic sub_sel;
	logic signed [OP_W-1:0] vre, vim, mre, mim;
	logic [WORD_W-1:0] q3;
	word_t init_v;
	cplx_t one_c, dp1, cmul_v;
	pc_t pc_nx;

	assign one_c  = creal(W_ONE);
	assign dp1    = cadd(d_q, one_c);
	assign vre    = OP_W'(d_q.re) + OP_W'(W_ONE);
	assign vim    = OP_W'(d_q.im);
	assign mre    = vre[OP_W-1] ? -vre : vre;
	assign mim    = vim[OP_W-1] ? -vim : vim;
	assign q3     = acc[ACC_W-1:ACC_W-WORD_W];
	assign near   = acc[2*WORD_W-1:0] <= {{(2*WORD_W-EPS_W-FRAC_W){1'b0}}, eps_q, {FRAC_W{1'b0}}};
	assign cmul_v = '{re: cre_q, im: sat_acc(acc)};

	always_comb begin
		init_v = word_t'(q3);
		if (k_q[1] ? vim[OP_W-1] : vre[OP_W-1]) init_v = -word_t'(q3);
	end

	always_comb begin
		case (job_q)
			JOB_NEAR: last_k = 3'd1;
			JOB_DIV:  last_k = 3'd5;
			default:  last_k = 3'd3;
		endcase
	end

	always_comb begin
		case (pc_q)
			PC_CHK:  pc_nx = PC_N0;
			PC_N0:   pc_nx = PC_N1;
			PC_N1:   pc_nx = PC_N2;
			PC_N2:   pc_nx = PC_T0;
			PC_T0:   pc_nx = (mode_q == MODE_GEN) ? PC_T1 : PC_M1;
			PC_T1:   pc_nx = PC_M0;
			PC_M0:   pc_nx = PC_M1;
			PC_M1:   pc_nx = PC_DIV;
			default: pc_nx = PC_CHK;
		endcase
	end

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		sub_sel = 1'b0;
		case (job_q)
			JOB_INIT: begin
				if (!k_q[0]) begin
					op_a = k_q[1] ? mim : mre;
					op_b = RECIP3;
				end
			end
			JOB_NEAR: begin
				op_a = OP_W'(k_q[0] ? opa_q.im : opa_q.re);
				op_b = op_a;
			end
			JOB_CMUL: begin
				case (k_q)
					3'd0: begin op_a = OP_W'(opa_q.re); op_b = OP_W'(opb_q.re); end
					3'd1: begin
						op_a = OP_W'(opa_q.im);
						op_b = OP_W'(opb_q.im);
						sub_sel = 1'b1;
					end
					3'd2: begin op_a = OP_W'(opa_q.re); op_b = OP_W'(opb_q.im); end
					default: begin op_a = OP_W'(opa_q.im); op_b = OP_W'(opb_q.re); end
				endcase
			end
			default: begin
				case (k_q)
					3'd0: begin op_a = OP_W'(opb_q.re); op_b = OP_W'(opb_q.re); end
					3'd1: begin op_a = OP_W'(opb_q.im); op_b = OP_W'(opb_q.im); end
					3'd2: begin op_a = OP_W'(opa_q.re); op_b = OP_W'(opb_q.re); end
					3'd3: begin op_a = OP_W'(opa_q.im); op_b = OP_W'(opb_q.im); end
					3'd4: begin op_a = OP_W'(opa_q.im); op_b = OP_W'(opb_q.re); end
					default: begin
						op_a = OP_W'(opa_q.re);
						op_b = OP_W'(opb_q.im);
						sub_sel = 1'b1;
					end
				endcase
			end
		endcase
	end

	always_comb begin
		st_d      = st_q;
		mac_ctl   = '0;
		div_start = 1'b0;
		case (st_q)
			ST_IDLE: if (in_valid) st_d = ST_MUL;
			ST_MUL: begin
				mac_ctl.mul = 1'b1;
				st_d = ST_ACC;
			end
			ST_ACC: begin
				mac_ctl.acc = 1'b1;
				mac_ctl.sub = sub_sel;
				mac_ctl.clr = !k_q[0];
				st_d = k_q[0] ? ST_RES : ST_MUL;
			end
			ST_RES: begin
				if (k_q != last_k) begin
					st_d = ST_MUL;
				end else begin
					case (job_q)
						JOB_NEAR: st_d = near ? ST_DONE : ST_PC;
						JOB_DIV:  st_d = ST_DIVGO;
						default:  st_d = ST_PC;
					endcase
				end
			end
			ST_PC: begin
				case (pc_q)
					PC_CHK:  if (i_q >= maxit_q) st_d = ST_DONE;
					PC_N2:   if (mode_q == MODE_GEN) st_d = ST_MUL;
					PC_T1:   if (mode_q == MODE_GEN) st_d = ST_MUL;
					PC_M1:   st_d = ST_PC;
					default: st_d = ST_MUL;
				endcase
			end
			ST_DIVGO: begin
				div_start = 1'b1;
				st_d = ST_DIVW;
			end
			ST_DIVW: if (div_done) st_d = dsel_q ? ST_PC : ST_DIVGO;
			ST_DONE: if (!out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			pc_q    <= PC_CHK;
			job_q   <= JOB_INIT;
			k_q     <= '0;
			i_q     <= '0;
			root_q  <= ROOT_NONE;
			dsel_q  <= 1'b0;
			mode_q  <= MODE_GEN;
			eps_q   <= EPS_W'(168);
			maxit_q <= CNT_W'(500);
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_EPS:   eps_q <= cfg_data;
					REG_MAXIT: maxit_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						i_q   <= '0;
						job_q <= JOB_INIT;
						k_q   <= '0;
						pc_q  <= PC_CHK;
						if (in_req.c_im == '0 && in_req.c_re == '0) mode_q <= MODE_ZERO;
						else if (in_req.c_im == '0 && in_req.c_re == W_ONE) mode_q <= MODE_ONE;
						else mode_q <= MODE_GEN;
					end
				end
				ST_ACC: if (!k_q[0]) k_q <= k_q + 3'd1;
				ST_RES: begin
					if (k_q != last_k) begin
						k_q <= k_q + 3'd1;
					end else if (job_q == JOB_NEAR) begin
						if (near) begin
							case (pc_q)
								PC_N0:   root_q <= ROOT_ZERO;
								PC_N1:   root_q <= ROOT_ONE;
								default: root_q <= ROOT_D;
							endcase
						end else begin
							pc_q <= pc_nx;
						end
					end else if (job_q == JOB_CMUL) begin
						pc_q <= pc_nx;
					end else if (job_q == JOB_DIV) begin
						dsel_q <= 1'b0;
					end
				end
				ST_PC: begin
					k_q <= '0;
					case (pc_q)
						PC_CHK: begin
							if (i_q >= maxit_q) root_q <= ROOT_NONE;
							else pc_q <= PC_N0;
						end
						PC_N0, PC_N1: job_q <= JOB_NEAR;
						PC_N2: begin
							job_q <= JOB_NEAR;
							if (mode_q != MODE_GEN) pc_q <= PC_T0;
						end
						PC_T0, PC_M0: job_q <= JOB_CMUL;
						PC_T1: begin
							job_q <= JOB_CMUL;
							if (mode_q != MODE_GEN) pc_q <= PC_M1;
						end
						PC_M1: pc_q <= PC_DIV;
						default: job_q <= JOB_DIV;
					endcase
				end
				ST_DIVW: begin
					if (div_done) begin
						dsel_q <= 1'b1;
						if (dsel_q) begin
							i_q  <= i_q + 1'b1;
							pc_q <= PC_CHK;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_valid) d_q <= '{re: in_req.c_re, im: in_req.c_im};
			ST_RES: begin
				case (job_q)
					JOB_INIT: begin
						if (k_q == 3'd1) x_q.re <= init_v;
						if (k_q == 3'd3) x_q.im <= init_v;
					end
					JOB_CMUL: begin
						if (k_q == 3'd1) cre_q <= sat_acc(acc);
						if (k_q == 3'd3) begin
							if (pc_q == PC_M0) m_q <= cmul_v;
							else t_q <= cmul_v;
						end
					end
					JOB_DIV: begin
						if (k_q == 3'd1) den_q <= acc[2*WORD_W-1:0];
						if (k_q == 3'd3) nre_q <= acc;
						if (k_q == 3'd5) nim_q <= acc;
					end
					default: ;
				endcase
			end
			ST_PC: begin
				case (pc_q)
					PC_N0: opa_q <= x_q;
					PC_N1: opa_q <= csub(x_q, one_c);
					PC_N2: opa_q <= csub(x_q, d_q);
					PC_T0: begin
						case (mode_q)
							MODE_ZERO: begin
								opa_q <= x_q;
								opb_q <= csub(cx2(x_q), one_c);
							end
							MODE_ONE: begin
								opa_q <= cx2(x_q);
								opb_q <= x_q;
							end
							default: begin
								opa_q <= x_q;
								opb_q <= x_q;
							end
						endcase
					end
					PC_T1: begin
						opa_q <= t_q;
						opb_q <= csub(csub(cx2(x_q), d_q), one_c);
					end
					PC_M0: begin
						opa_q <= csub(cx3(x_q), cx2(dp1));
						opb_q <= x_q;
					end
					PC_M1: begin
						case (mode_q)
							MODE_ZERO: m_q <= csub(cx3(x_q), creal(W_TWO));
							MODE_ONE:  m_q <= csub(cx3(x_q), one_c);
							default:   m_q <= cadd(m_q, d_q);
						endcase
					end
					PC_DIV: begin
						opa_q <= t_q;
						opb_q <= m_q;
					end
					default: ;
				endcase
			end
			ST_DIVW: begin
				if (div_done) begin
					if (dsel_q) x_q.im <= div_quo;
					else x_q.re <= div_quo;
				end
			end
			default: ;
		endcase
	end

	cnr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	cnr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dsel_q ? nim_q : nre_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_DONE);
	assign out_req   = '{root_found: root_q, iterations: i_q};

endmodule
